/* hdl/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants
// Point, item and result formats for the split closest-pair distance block.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_DIMS   = 4;
  localparam int DIM_W      = 3;                   // num_dims register width
  localparam int MIN_W      = 17;                  // init_min and result minima
  localparam int SQ_W       = 35;                  // squared distances
  localparam int ROOT_W     = 18;                  // full root of an SQ_W value
  localparam int PAIR_W     = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_MIN = CFG_IDX_W'(1);

  localparam int                  RESET_INIT_MIN = 100;
  localparam logic [DIM_W-1:0]    RESET_NUM_DIMS = DIM_W'(2);
  localparam logic [SQ_W-1:0]     INIT_SQ_RST    = SQ_W'(RESET_INIT_MIN * RESET_INIT_MIN);
  localparam logic [PAIR_W-1:0]   PAIRS_MAX      = {PAIR_W{1'b1}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [MAX_DIMS-1:0]        point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_0;
    logic signed [COORD_BITS-1:0] coord_1;
    logic signed [COORD_BITS-1:0] coord_2;
    logic signed [COORD_BITS-1:0] coord_3;
    logic                         last_point;
  } in_t;

  typedef struct packed {
    logic [MIN_W-1:0]  min_left;
    logic [MIN_W-1:0]  min_right;
    logic [PAIR_W-1:0] pair_count;
    logic              overflow;
  } out_t;

  // per-cell control of the point chain
  typedef struct packed {
    logic shift;   // take neighbor (or head on wrap)
    logic wrap;    // this cell is the tail of the occupied ring
    logic load;    // store the new point here
  } cell_ctrl_t;

  // distance pipeline result
  typedef struct packed {
    logic            valid;
    logic            hit;    // stored point is on the same side
    logic [SQ_W-1:0] sq;
  } dist_res_t;

endpackage

/* hdl/scp_cell.sv */
// ----------------------------------------------------------------------------
// scp_cell: one point slot of the storage chain
// Holds a point; rotates toward the head or loads a new point.
// ----------------------------------------------------------------------------
module scp_cell (
  input  logic                clk,
  input  scp_pkg::cell_ctrl_t ctrl,
  input  scp_pkg::point_t     nbr,
  input  scp_pkg::point_t     head,
  input  scp_pkg::point_t     new_pt,
  output scp_pkg::point_t     pt
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pt <= new_pt;
    end else if (ctrl.shift) begin
      pt <= ctrl.wrap ? head : nbr;
    end
  end

endmodule

/* hdl/scp_dist.sv */
// ----------------------------------------------------------------------------
// scp_dist: squared distance pipeline
// Three stages: lane differences, lane squares, sum. One pair per cycle.
// ----------------------------------------------------------------------------
module scp_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue,
  input  scp_pkg::point_t               new_pt,
  input  scp_pkg::point_t               head,
  input  logic [scp_pkg::MAX_DIMS-1:0]  lane_en,
  input  logic                          new_neg,
  input  logic                          new_pos,
  output scp_pkg::dist_res_t            res,
  output logic                          busy
);

  localparam int DW = scp_pkg::COORD_BITS + 1;
  localparam int PW = 2 * scp_pkg::COORD_BITS;

  logic                                 s1_valid, s2_valid, s3_valid;
  logic                                 s1_hit, s2_hit, s3_hit;
  logic signed [DW-1:0]                 s1_diff [scp_pkg::MAX_DIMS];
  logic [PW-1:0]                        s2_sq   [scp_pkg::MAX_DIMS];
  logic [scp_pkg::SQ_W-1:0]             s3_sum;

  logic                                 head_neg, head_pos, hit;
  logic signed [DW-1:0]                 diff    [scp_pkg::MAX_DIMS];
  logic [scp_pkg::COORD_BITS-1:0]       mag     [scp_pkg::MAX_DIMS];
  logic [scp_pkg::SQ_W-1:0]             sum;

  assign head_neg = head[0][scp_pkg::COORD_BITS-1];
  assign head_pos = !head_neg && (head[0] != '0);
  assign hit      = (new_neg && head_neg) || (new_pos && head_pos);

  always_comb begin
    for (int d = 0; d < scp_pkg::MAX_DIMS; d++) begin
      diff[d] = $signed({new_pt[d][scp_pkg::COORD_BITS-1], new_pt[d]})
              - $signed({head[d][scp_pkg::COORD_BITS-1], head[d]});
      mag[d]  = s1_diff[d][DW-1] ? scp_pkg::COORD_BITS'(-s1_diff[d])
                                 : scp_pkg::COORD_BITS'(s1_diff[d]);
    end
    sum = '0;
    for (int d = 0; d < scp_pkg::MAX_DIMS; d++) begin
      sum = sum + scp_pkg::SQ_W'(s2_sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit <= hit;
    s2_hit <= s1_hit;
    s3_hit <= s2_hit;
    for (int d = 0; d < scp_pkg::MAX_DIMS; d++) begin
      s1_diff[d] <= lane_en[d] ? diff[d] : '0;
      s2_sq[d]   <= mag[d] * mag[d];
    end
    s3_sum <= sum;
  end

  assign res.valid = s3_valid;
  assign res.hit   = s3_hit;
  assign res.sq    = s3_sum;
  assign busy      = s1_valid || s2_valid || s3_valid;

endmodule

/* hdl/scp_isqrt.sv */
// ----------------------------------------------------------------------------
// scp_isqrt: integer square root, one result bit per cycle
// Restoring digit-by-digit method; root holds its final value once busy drops.
// ----------------------------------------------------------------------------
module scp_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [scp_pkg::SQ_W-1:0]   value,
  output logic                       busy,
  output logic [scp_pkg::ROOT_W-1:0] root
);

  localparam int XW    = 2 * scp_pkg::ROOT_W;
  localparam int REM_W = scp_pkg::ROOT_W + 2;
  localparam int CW    = $clog2(scp_pkg::ROOT_W + 1);

  logic [XW-1:0]               x;
  logic [REM_W-1:0]            rem, rem_next;
  logic [scp_pkg::ROOT_W-1:0]  root_next;
  logic [CW-1:0]               cnt;
  logic [REM_W+1:0]            rem_sh, trial;

  always_comb begin
    rem_sh = {rem, x[XW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = REM_W'(rem_sh - trial);
      root_next = {root[scp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = REM_W'(rem_sh);
      root_next = {root[scp_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(scp_pkg::ROOT_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= XW'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= x << 2;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

/* hdl/split_closest_pair_distance_top.sv */
// ----------------------------------------------------------------------------
// split_closest_pair_distance_top: per-side closest pair over a point set
// Flow: a point is taken only while idle; in_stall then holds the input while
//   the point is scanned, if it can pair, and parked; a dropped point that does not
//   close the set stalls nothing. The result of a set follows its last point
//   stored or dropped, via two square roots that run side by side.
// Reset (rst, synchronous) clears counts and flags and resets minima, not points.
// ----------------------------------------------------------------------------
module split_closest_pair_distance_top #(
  parameter int MAX_POINTS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // point items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  scp_pkg::in_t                      in_data,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output scp_pkg::out_t                     out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scp_pkg::MIN_W-1:0]         cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,       // rotate occupied cells through the distance pipeline
    S_DRAIN,      // let the last pairs leave the pipeline
    S_INSERT,     // park the new point behind the occupied cells
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [CNT_W-1:0]               count, scan_cnt;
  logic [scp_pkg::PAIR_W-1:0]     pairs;
  logic                           dropped;
  logic [scp_pkg::SQ_W-1:0]       best_left, best_right, init_sq;
  logic [scp_pkg::DIM_W-1:0]      num_dims;

  scp_pkg::point_t                new_pt, in_pt;
  logic                           new_last;
  logic                           new_neg, new_pos;

  logic                           in_acc, out_free;
  logic [scp_pkg::DIM_W-1:0]      dims_eff;
  logic [scp_pkg::MAX_DIMS-1:0]   lane_en;
  logic [2*scp_pkg::MIN_W-1:0]    cfg_prod;
  logic [scp_pkg::SQ_W-1:0]       cfg_sq;

  scp_pkg::point_t                cell_pt   [MAX_POINTS];
  scp_pkg::cell_ctrl_t            cell_ctrl [MAX_POINTS];

  scp_pkg::dist_res_t             dres;
  logic                           dist_busy;
  logic                           root_start, root_l_busy, root_r_busy;
  logic [scp_pkg::ROOT_W-1:0]     root_l, root_r;

  // --------------------------------------------------------------------------
  // Handshakes. Registers may be written any time the block is idle.
  // --------------------------------------------------------------------------
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign in_pt[0] = in_data.coord_0;
  assign in_pt[1] = in_data.coord_1;
  assign in_pt[2] = in_data.coord_2;
  assign in_pt[3] = in_data.coord_3;

  // side of the point under work
  assign new_neg = new_pt[0][scp_pkg::COORD_BITS-1];
  assign new_pos = !new_neg && (new_pt[0] != '0);

  // num_dims clamped to 1..MAX_DIMS; unused lanes contribute zero
  always_comb begin
    if (num_dims == '0) begin
      dims_eff = scp_pkg::DIM_W'(1);
    end else if (num_dims > scp_pkg::DIM_W'(scp_pkg::MAX_DIMS)) begin
      dims_eff = scp_pkg::DIM_W'(scp_pkg::MAX_DIMS);
    end else begin
      dims_eff = num_dims;
    end
    for (int d = 0; d < scp_pkg::MAX_DIMS; d++) begin
      lane_en[d] = scp_pkg::DIM_W'(d) < dims_eff;
    end
  end

  // new ceiling squared, taken straight off the write port
  assign cfg_prod = cfg_data * cfg_data;
  assign cfg_sq   = scp_pkg::SQ_W'(cfg_prod);

  // --------------------------------------------------------------------------
  // Point chain. Cells 0..count-1 hold the set; during a scan they rotate as
  // a ring (the tail takes cell 0), so a full scan brings the order back.
  // Cell 0 is the head that feeds the distance pipeline.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int NXT = (k + 1) % MAX_POINTS;

    assign cell_ctrl[k].shift = (state == S_SCAN) && (CNT_W'(k) < count);
    assign cell_ctrl[k].wrap  = (CNT_W'(k + 1) == count);
    assign cell_ctrl[k].load  = (state == S_INSERT) && (CNT_W'(k) == count);

    scp_cell u_cell (
      .clk    (clk),
      .ctrl   (cell_ctrl[k]),
      .nbr    (cell_pt[NXT]),
      .head   (cell_pt[0]),
      .new_pt (new_pt),
      .pt     (cell_pt[k])
    );
  end

  scp_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .issue   (state == S_SCAN),
    .new_pt  (new_pt),
    .head    (cell_pt[0]),
    .lane_en (lane_en),
    .new_neg (new_neg),
    .new_pos (new_pos),
    .res     (dres),
    .busy    (dist_busy)
  );

  // --------------------------------------------------------------------------
  // Square roots of both minima at the end of a set
  // --------------------------------------------------------------------------
  assign root_start = (state == S_ROOT_GO);

  scp_isqrt u_root_left (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best_left),
    .busy  (root_l_busy),
    .root  (root_l)
  );

  scp_isqrt u_root_right (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best_right),
    .busy  (root_r_busy),
    .root  (root_r)
  );

  // point under work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_pt   <= in_pt;
      new_last <= in_data.last_point;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, set state, registers and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      scan_cnt   <= '0;
      pairs      <= '0;
      dropped    <= 1'b0;
      best_left  <= scp_pkg::INIT_SQ_RST;
      best_right <= scp_pkg::INIT_SQ_RST;
      init_sq    <= scp_pkg::INIT_SQ_RST;
      num_dims   <= scp_pkg::RESET_NUM_DIMS;
      out_valid  <= 1'b0;
      out_data   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // a new ceiling also reloads both minima
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          scp_pkg::REG_NUM_DIMS: begin
            num_dims <= cfg_data[scp_pkg::DIM_W-1:0];
          end
          scp_pkg::REG_INIT_MIN: begin
            init_sq    <= cfg_sq;
            best_left  <= cfg_sq;
            best_right <= cfg_sq;
          end
          default: begin
          end
        endcase
      end

      // same-side pair out of the pipeline
      if (dres.valid && dres.hit) begin
        if (new_neg) begin
          if (dres.sq < best_left) begin
            best_left <= dres.sq;
          end
        end else begin
          if (dres.sq < best_right) begin
            best_right <= dres.sq;
          end
        end
        if (pairs != scp_pkg::PAIRS_MAX) begin
          pairs <= pairs + scp_pkg::PAIR_W'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            scan_cnt <= '0;
            if (count == CNT_W'(MAX_POINTS)) begin
              // store full: point dropped, still closes the set if marked
              dropped <= 1'b1;
              if (in_data.last_point) begin
                state <= S_ROOT_GO;
              end
            end else if (in_data.coord_0 == '0 || count == '0) begin
              state <= S_INSERT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + CNT_W'(1);
          if (scan_cnt == count - CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!dist_busy) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          count <= count + CNT_W'(1);
          state <= new_last ? S_ROOT_GO : S_IDLE;
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (!root_l_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.min_left   <= root_l[scp_pkg::MIN_W-1:0];
            out_data.min_right  <= root_r[scp_pkg::MIN_W-1:0];
            out_data.pair_count <= pairs;
            out_data.overflow   <= dropped;
            // fresh set
            count      <= '0;
            pairs      <= '0;
            dropped    <= 1'b0;
            best_left  <= init_sq;
            best_right <= init_sq;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dres.valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("distance result outside a scan");

  a_min_ceiling: assert property (@(posedge clk) disable iff (rst)
    (best_left <= init_sq) && (best_right <= init_sq))
    else $error("minimum above the ceiling");

  a_roots_paired: assert property (@(posedge clk) disable iff (rst)
    root_l_busy == root_r_busy)
    else $error("square root units out of step");

  a_no_emit_over_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> (state == S_EMIT))
    else $error("result written over a waiting result");

endmodule
